### hw/rtl/cra_pkg.sv
`default_nettype none
package cra_pkg;

  localparam int unsigned RES_LIMIT   = 8;
  localparam logic [15:0] TIMEOUT_RST = 16'd5000;
  localparam logic [24:0] SUM_MAX     = 25'h1FFFFFF;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_CHUNK = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_FLUSH = 2'd3
  } cra_action_e;

  typedef enum logic [3:0] {
    STS_STORED    = 4'd0,
    STS_HDR_ONLY  = 4'd1,
    STS_ACCEPTED  = 4'd2,
    STS_COMPLETE  = 4'd3,
    STS_SHORT     = 4'd4,
    STS_OVERFLOW  = 4'd5,
    STS_UNKNOWN   = 4'd6,
    STS_BAD_INDEX = 4'd7,
    STS_DUPLICATE = 4'd8,
    STS_STALE     = 4'd9,
    STS_FULL      = 4'd10,
    STS_TOO_MANY  = 4'd11,
    STS_IN_FLIGHT = 4'd12
  } cra_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENTRY,
    ST_TICK_RD,
    ST_TICK_WR,
    ST_FINISH
  } cra_state_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] frame_tag;
    logic [15:0] chunk_pos;
    logic [15:0] chunk_cnt;
    logic [23:0] frame_len;
    logic [23:0] chunk_len;
  } cra_in_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] result_tag;
    logic [24:0] assembled_bytes;
    logic        last;
  } cra_out_t;

endpackage
`default_nettype wire

### hw/rtl/cra_ram.sv
`default_nettype none
module cra_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  wire                                      clk_i,
  input  wire                                      we_i,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]                         wdata_i,
  input  wire                                      re_i,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/chunk_reassembly_tracker.sv
`default_nettype none
// Chunk reassembly tracker.
// Input channel in_valid_i/in_stall_o carries one beat per start, chunk, tick
// or flush. Output channel out_valid_o/out_stall_i carries status beats; the
// last beat caused by an input has last set. Flush and a tick that drops
// nothing produce no beat.
// Tag lookup runs in parallel over the valid flags and tag registers; the rest
// of each entry lives in a one-port-read entry RAM.
// Start and chunk go through lookup, RAM read and read-modify-write, then the
// result hand-off to the output register.
// A tick sweeps the slots one by one: a free slot is only checked, a live slot
// is read and then written back, and a final hand-off follows.
// A stalled receiver holds the output register; the block waits only when it
// has a new beat to hand off and the register is still full.
// Reset clears the valid flags and the output valid flag, and sets timeout_ticks to
// 5000; entry RAM contents need no clearing. Write timeout_ticks over the APB
// port at address 0 while idle.
module chunk_reassembly_tracker
  import cra_pkg::*;
#(
  parameter int unsigned MAX_FRAMES = 8,
  parameter int unsigned MAX_CHUNKS = 64
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_stall_o,
  input  wire  cra_in_t    in_data_i,
  output logic             out_valid_o,
  input  wire              out_stall_i,
  output cra_out_t         out_data_o,
  input  wire              psel,
  input  wire              penable,
  input  wire              pwrite,
  input  wire  [2:0]       paddr,
  input  wire  [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned SW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned CW = $clog2(MAX_CHUNKS + 1);
  localparam int unsigned IW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;

  typedef struct packed {
    logic [31:0]           tag;
    logic [CW-1:0]         total;
    logic [CW-1:0]         recv;
    logic [23:0]           size;
    logic [24:0]           sum;
    logic [15:0]           age;
    logic [MAX_CHUNKS-1:0] seen;
  } entry_t;

  localparam int unsigned EW = $bits(entry_t);

  cra_state_e            state_q, state_d;
  cra_in_t               item_q, item_d;
  logic [SW-1:0]         slot_q, slot_d;
  logic                  pend_v_q, pend_v_d;
  cra_out_t              pend_q, pend_d;
  logic [3:0]            rpt_q, rpt_d;
  logic [MAX_FRAMES-1:0] valid_q, valid_d;
  logic [31:0]           tag_q [MAX_FRAMES];
  logic [31:0]           tag_d [MAX_FRAMES];
  logic [15:0]           timeout_q;
  logic                  out_valid_q, out_valid_d;
  cra_out_t              out_q, out_d;

  logic          ram_we, ram_re;
  logic [SW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, rd;
  logic [EW-1:0] rdata_raw;

  logic          acc, can_push, last_slot;
  logic          hit, free_hit, hdr_only;
  logic [SW-1:0] hit_slot, free_slot;
  logic [15:0]   age_n;
  logic          stale, report, tick_hold;

  // chunk update
  logic          bad_idx, dup;
  logic [IW-1:0] bit_idx;
  logic [CW-1:0] recv_n;
  logic [25:0]   sum_w;
  logic [24:0]   sum_n;
  logic [MAX_CHUNKS-1:0] seen_n;

  cra_ram #(.WIDTH(EW), .DEPTH(MAX_FRAMES)) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata_raw)
  );
  assign rd = entry_t'(rdata_raw);

  assign in_stall_o  = (state_q != ST_IDLE);
  assign acc         = in_valid_i && !in_stall_o;
  assign can_push    = !out_valid_q || !out_stall_i;
  assign last_slot   = (slot_q == SW'(MAX_FRAMES - 1));
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pready      = 1'b1;
  assign prdata      = (paddr[2] == 1'b0) ? {16'd0, timeout_q} : 32'd0;
  assign hdr_only    = (in_data_i.chunk_cnt == 16'd0) && (in_data_i.frame_len == 24'd0);

  always_comb begin
    hit       = 1'b0;
    hit_slot  = '0;
    free_hit  = 1'b0;
    free_slot = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if (valid_q[i] && tag_q[i] == in_data_i.frame_tag) begin
        hit      = 1'b1;
        hit_slot = SW'(i);
      end
      if (!valid_q[i]) begin
        free_hit  = 1'b1;
        free_slot = SW'(i);
      end
    end
  end

  assign age_n     = (rd.age == 16'hFFFF) ? rd.age : rd.age + 16'd1;
  assign stale     = age_n > timeout_q;
  assign report    = rpt_q < 4'(RES_LIMIT);
  assign tick_hold = stale && report && pend_v_q && !can_push;

  always_comb begin
    bad_idx = (item_q.chunk_pos >= 16'(rd.total)) ||
              (item_q.chunk_pos >= 16'(MAX_CHUNKS));
    bit_idx = item_q.chunk_pos[IW-1:0];
    dup     = bad_idx ? 1'b0 : rd.seen[bit_idx];
    seen_n  = rd.seen;
    seen_n[bit_idx] = 1'b1;
    recv_n  = rd.recv + CW'(1);
    sum_w   = {1'b0, rd.sum} + {2'b00, item_q.chunk_len};
    sum_n   = sum_w[25] ? SUM_MAX : sum_w[24:0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          unique case (cra_action_e'(in_data_i.action))
            ACT_START: state_d = (!hdr_only && hit) ? ST_ENTRY : ST_FINISH;
            ACT_CHUNK: state_d = hit ? ST_ENTRY : ST_FINISH;
            ACT_TICK:  state_d = ST_TICK_RD;
            ACT_FLUSH: state_d = ST_IDLE;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_ENTRY: state_d = ST_FINISH;
      ST_TICK_RD: begin
        if (valid_q[slot_q]) begin
          state_d = ST_TICK_WR;
        end else if (last_slot) begin
          state_d = ST_FINISH;
        end
      end
      ST_TICK_WR: begin
        if (!tick_hold) begin
          state_d = last_slot ? ST_FINISH : ST_TICK_RD;
        end
      end
      ST_FINISH: begin
        if (!pend_v_q || can_push) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    item_d      = item_q;
    slot_d      = slot_q;
    pend_v_d    = pend_v_q;
    pend_d      = pend_q;
    rpt_d       = rpt_q;
    valid_d     = valid_q;
    tag_d       = tag_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = slot_q;
    ram_raddr   = slot_q;
    ram_wdata   = rd;

    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          item_d    = in_data_i;
          slot_d    = hit_slot;
          ram_raddr = hit_slot;
          pend_v_d  = 1'b1;
          pend_d    = '{status: STS_STORED, result_tag: in_data_i.frame_tag,
                        assembled_bytes: 25'd0, last: 1'b1};
          unique case (cra_action_e'(in_data_i.action))
            ACT_START: begin
              if (hdr_only) begin
                pend_d.status = STS_HDR_ONLY;
              end else if (hit) begin
                ram_re   = 1'b1;
                pend_v_d = 1'b0;
              end else if (in_data_i.chunk_cnt > 16'(MAX_CHUNKS)) begin
                pend_d.status = STS_TOO_MANY;
              end else if (free_hit) begin
                ram_we             = 1'b1;
                ram_waddr          = free_slot;
                ram_wdata          = '0;
                ram_wdata.tag      = in_data_i.frame_tag;
                ram_wdata.total    = in_data_i.chunk_cnt[CW-1:0];
                ram_wdata.size     = in_data_i.frame_len;
                valid_d[free_slot] = 1'b1;
                tag_d[free_slot]   = in_data_i.frame_tag;
              end else begin
                pend_d.status = STS_FULL;
              end
            end
            ACT_CHUNK: begin
              if (hit) begin
                ram_re   = 1'b1;
                pend_v_d = 1'b0;
              end else begin
                pend_d.status = STS_UNKNOWN;
              end
            end
            ACT_TICK: begin
              slot_d   = '0;
              rpt_d    = '0;
              pend_v_d = 1'b0;
            end
            ACT_FLUSH: begin
              valid_d  = '0;
              pend_v_d = 1'b0;
            end
            default: pend_v_d = 1'b0;
          endcase
        end
      end
      ST_ENTRY: begin
        pend_v_d = 1'b1;
        pend_d   = '{status: STS_IN_FLIGHT, result_tag: item_q.frame_tag,
                     assembled_bytes: rd.sum, last: 1'b1};
        if (cra_action_e'(item_q.action) == ACT_CHUNK) begin
          priority if (bad_idx) begin
            pend_d.status = STS_BAD_INDEX;
          end else if (dup) begin
            pend_d.status = STS_DUPLICATE;
          end else begin
            ram_we                 = 1'b1;
            ram_wdata.seen         = seen_n;
            ram_wdata.recv         = recv_n;
            ram_wdata.sum          = sum_n;
            pend_d.assembled_bytes = sum_n;
            if (recv_n < rd.total) begin
              pend_d.status = STS_ACCEPTED;
            end else begin
              valid_d[slot_q] = 1'b0;
              if (sum_n > {1'b0, rd.size}) begin
                pend_d.status = STS_OVERFLOW;
              end else if (sum_n == {1'b0, rd.size}) begin
                pend_d.status = STS_COMPLETE;
              end else begin
                pend_d.status = STS_SHORT;
              end
            end
          end
        end
      end
      ST_TICK_RD: begin
        if (valid_q[slot_q]) begin
          ram_re = 1'b1;
        end else if (!last_slot) begin
          slot_d = slot_q + SW'(1);
        end
      end
      ST_TICK_WR: begin
        if (!tick_hold) begin
          ram_we        = 1'b1;
          ram_wdata.age = age_n;
          if (stale) begin
            valid_d[slot_q] = 1'b0;
            if (report) begin
              // push the held stale beat; it is not the final one
              if (pend_v_q) begin
                out_valid_d = 1'b1;
                out_d       = pend_q;
                out_d.last  = 1'b0;
              end
              pend_v_d = 1'b1;
              pend_d   = '{status: STS_STALE, result_tag: rd.tag,
                           assembled_bytes: rd.sum, last: 1'b1};
              rpt_d    = rpt_q + 4'd1;
            end
          end
          if (!last_slot) begin
            slot_d = slot_q + SW'(1);
          end
        end
      end
      ST_FINISH: begin
        if (pend_v_q && can_push) begin
          out_valid_d = 1'b1;
          out_d       = pend_q;
          pend_v_d    = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_v_q    <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      rpt_q       <= '0;
      timeout_q   <= TIMEOUT_RST;
    end else begin
      state_q     <= state_d;
      pend_v_q    <= pend_v_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
      rpt_q       <= rpt_d;
      if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
        timeout_q <= pwdata[15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    slot_q <= slot_d;
    pend_q <= pend_d;
    out_q  <= out_d;
    tag_q  <= tag_d;
  end

`ifndef SYNTH
  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_data_i.action == ACT_FLUSH |=> valid_q == '0)
    else $error("flush left a live entry");
  a_entry_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ENTRY |-> valid_q[slot_q])
    else $error("entry update on a free slot");
  a_rpt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rpt_q <= 4'(RES_LIMIT))
    else $error("stale report count past limit");
  a_alloc_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we && state_q == ST_IDLE |-> !valid_q[ram_waddr])
    else $error("allocation over a live slot");
`endif

endmodule
`default_nettype wire
